>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types, codes and character helpers for the tokenizer
// Result item layout, configuration bundle and byte classification functions.
// ----------------------------------------------------------------------------
package stt_pkg;

    // item kinds
    localparam logic [1:0] ITEM_CHAR = 2'd0;
    localparam logic [1:0] ITEM_END  = 2'd1;
    localparam logic [1:0] ITEM_ERR  = 2'd2;

    // token classes
    localparam logic [4:0] CLS_IDENT     = 5'd0;
    localparam logic [4:0] CLS_NUMBER    = 5'd1;
    localparam logic [4:0] CLS_SPACES    = 5'd2;
    localparam logic [4:0] CLS_EOF       = 5'd3;
    localparam logic [4:0] CLS_OPERATOR  = 5'd4;
    localparam logic [4:0] CLS_PAREN     = 5'd5;
    localparam logic [4:0] CLS_BRACE     = 5'd6;
    localparam logic [4:0] CLS_NEWLINE   = 5'd7;
    localparam logic [4:0] CLS_TAB       = 5'd8;
    localparam logic [4:0] CLS_BRACKET   = 5'd9;
    localparam logic [4:0] CLS_CHAR      = 5'd10;
    localparam logic [4:0] CLS_STRING    = 5'd11;
    localparam logic [4:0] CLS_DOT       = 5'd12;
    localparam logic [4:0] CLS_COLON     = 5'd13;
    localparam logic [4:0] CLS_SEMICOLON = 5'd14;
    localparam logic [4:0] CLS_GREATER   = 5'd15;
    localparam logic [4:0] CLS_LESS      = 5'd16;
    localparam logic [4:0] CLS_OTHER     = 5'd17;
    localparam logic [4:0] CLS_PERCENT   = 5'd18;
    localparam logic [4:0] CLS_BAR       = 5'd19;
    localparam logic [4:0] CLS_COMMENT   = 5'd20;
    localparam logic [4:0] CLS_ESCAPE    = 5'd21;

    // error codes
    localparam logic [2:0] ERR_OPEN_COMMENT  = 3'd1;
    localparam logic [2:0] ERR_OPEN_STRING   = 3'd2;
    localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd3;
    localparam logic [2:0] ERR_EMPTY_CHAR    = 3'd4;
    localparam logic [2:0] ERR_UNCLOSED_CHAR = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_SPACES   = 2'd0;
    localparam logic [1:0] REG_TABS     = 2'd1;
    localparam logic [1:0] REG_NEWLINES = 2'd2;
    localparam logic [1:0] REG_COMMENTS = 2'd3;

    // bytes of interest
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_BEL     = 8'h07;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_B    = 8'h62;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_LO_N    = 8'h6E;
    localparam logic [7:0] CH_LO_R    = 8'h72;
    localparam logic [7:0] CH_LO_T    = 8'h74;
    localparam logic [7:0] CH_LO_V    = 8'h76;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef struct packed {
        logic [2:0] error_code;
        logic [4:0] token_class;
        logic [7:0] char_value;
        logic [1:0] item_type;
    } t_res;

    typedef struct packed {
        logic comments_enable;
        logic newlines_enable;
        logic tabs_enable;
        logic spaces_enable;
    } t_cfg;

    // results of one byte, slot 0 first
    typedef struct packed {
        t_res [3:0] res;
        logic [2:0] cnt;
    } t_lex_out;

    function automatic t_res mk_char(input logic [7:0] c);
        t_res r;
        r             = '0;
        r.item_type   = ITEM_CHAR;
        r.char_value  = c;
        return r;
    endfunction

    function automatic t_res mk_end(input logic [4:0] cls);
        t_res r;
        r             = '0;
        r.item_type   = ITEM_END;
        r.token_class = cls;
        return r;
    endfunction

    function automatic t_res mk_err(input logic [2:0] e);
        t_res r;
        r            = '0;
        r.item_type  = ITEM_ERR;
        r.error_code = e;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
    endfunction

    // escape letter accepted after a backslash in strings and chars
    function automatic logic lit_escape(input logic [7:0] c);
        logic ok;
        case (c) inside
            CH_LO_N, CH_LO_T, CH_LO_V, CH_LO_R, CH_LO_F, CH_LO_B, CH_LO_A,
            CH_BSLASH, CH_QMARK, CH_DQUOTE, CH_QUOTE, CH_ZERO: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // second character of the two-character form of a raw byte, NUL if none
    function automatic logic [7:0] raw_form(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_NL:     r = CH_LO_N;
            CH_TAB:    r = CH_LO_T;
            CH_VT:     r = CH_LO_V;
            CH_CR:     r = CH_LO_R;
            CH_FF:     r = CH_LO_F;
            CH_BS:     r = CH_LO_B;
            CH_BEL:    r = CH_LO_A;
            CH_BSLASH: r = CH_BSLASH;
            CH_QMARK:  r = CH_QMARK;
            CH_DQUOTE: r = CH_DQUOTE;
            CH_QUOTE:  r = CH_QUOTE;
            default:   r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/stt_lexer.sv
// ----------------------------------------------------------------------------
// stt_lexer: lexer state and per-byte result logic
// Holds the lexer mode and run flags, and decodes one byte into up to four
// result items in a single pass.
// ----------------------------------------------------------------------------
module stt_lexer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_char,
    input  stt_pkg::t_cfg      i_cfg,
    output stt_pkg::t_lex_out  o_lex
);

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_IDENT      = 4'd1;
    localparam logic [3:0] M_SPACES     = 4'd2;
    localparam logic [3:0] M_SLASH      = 4'd3;
    localparam logic [3:0] M_BLOCK_KEEP = 4'd4;
    localparam logic [3:0] M_BSTAR_KEEP = 4'd5;
    localparam logic [3:0] M_BLOCK_DROP = 4'd6;
    localparam logic [3:0] M_BSTAR_DROP = 4'd7;
    localparam logic [3:0] M_LINE_KEEP  = 4'd8;
    localparam logic [3:0] M_LINE_DROP  = 4'd9;
    localparam logic [3:0] M_ESCAPE     = 4'd10;
    localparam logic [3:0] M_STRING     = 4'd11;
    localparam logic [3:0] M_STR_ESC    = 4'd12;
    localparam logic [3:0] M_CHAR_FIRST = 4'd13;
    localparam logic [3:0] M_CHAR_ESC   = 4'd14;
    localparam logic [3:0] M_CHAR_CLOSE = 4'd15;

    logic [3:0] r_mode, n_mode;
    logic       r_dig, n_dig;
    logic       r_let, n_let;

    // start-of-token decode of the byte
    stt_pkg::t_res id_res [2];
    logic [1:0]    id_cnt;
    logic [3:0]    id_mode;
    logic          id_dig, id_let;

    // results of the current mode, placed ahead of the start-of-token results
    stt_pkg::t_res pre [4];
    logic [2:0]    pre_cnt;
    logic          do_idle;

    logic          keep, star;
    logic [7:0]    raw;

    assign keep = (r_mode == M_BLOCK_KEEP) || (r_mode == M_BSTAR_KEEP);
    assign star = (r_mode == M_BSTAR_KEEP) || (r_mode == M_BSTAR_DROP);
    assign raw  = stt_pkg::raw_form(i_char);

    always_comb begin
        id_res[0] = '0;
        id_res[1] = '0;
        id_cnt    = 2'd0;
        id_mode   = M_IDLE;
        id_dig    = r_dig;
        id_let    = r_let;
        if (stt_pkg::is_word(i_char)) begin
            id_dig    = stt_pkg::is_digit(i_char);
            id_let    = !stt_pkg::is_digit(i_char);
            id_mode   = M_IDENT;
            id_res[0] = stt_pkg::mk_char(i_char);
            id_cnt    = 2'd1;
        end else begin
            id_res[0] = stt_pkg::mk_char(i_char);
            id_cnt    = 2'd2;
            case (i_char) inside
                stt_pkg::CH_NUL: begin
                    id_res[0] = stt_pkg::mk_end(stt_pkg::CLS_EOF);
                    id_cnt    = 2'd1;
                end
                stt_pkg::CH_SLASH: begin
                    id_mode = M_SLASH;
                    id_cnt  = 2'd0;
                end
                stt_pkg::CH_CARET, stt_pkg::CH_STAR, stt_pkg::CH_PLUS,
                stt_pkg::CH_MINUS, stt_pkg::CH_EQ:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_OPERATOR);
                stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_PAREN);
                stt_pkg::CH_LBRACE, stt_pkg::CH_RBRACE:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_BRACE);
                stt_pkg::CH_LBRACK, stt_pkg::CH_RBRACK:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_BRACKET);
                stt_pkg::CH_BSLASH: begin
                    id_mode = M_ESCAPE;
                    id_cnt  = 2'd0;
                end
                stt_pkg::CH_TAB: begin
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_TAB);
                    id_cnt    = i_cfg.tabs_enable ? 2'd2 : 2'd0;
                end
                stt_pkg::CH_NL: begin
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_NEWLINE);
                    id_cnt    = i_cfg.newlines_enable ? 2'd2 : 2'd0;
                end
                stt_pkg::CH_DQUOTE: begin
                    id_mode = M_STRING;
                    id_cnt  = 2'd0;
                end
                stt_pkg::CH_QUOTE: begin
                    id_mode = M_CHAR_FIRST;
                    id_cnt  = 2'd0;
                end
                stt_pkg::CH_SPACE: begin
                    id_mode = i_cfg.spaces_enable ? M_SPACES : M_IDLE;
                    id_cnt  = i_cfg.spaces_enable ? 2'd1 : 2'd0;
                end
                stt_pkg::CH_DOT:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_DOT);
                stt_pkg::CH_COLON:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_COLON);
                stt_pkg::CH_SEMI:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_SEMICOLON);
                stt_pkg::CH_GT:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_GREATER);
                stt_pkg::CH_LT:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_LESS);
                stt_pkg::CH_BAR:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_BAR);
                stt_pkg::CH_PERCENT:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_PERCENT);
                default:
                    id_res[1] = stt_pkg::mk_end(stt_pkg::CLS_OTHER);
            endcase
        end
    end

    always_comb begin
        pre[0]  = '0;
        pre[1]  = '0;
        pre[2]  = '0;
        pre[3]  = '0;
        pre_cnt = 3'd0;
        do_idle = 1'b0;
        n_mode  = r_mode;
        n_dig   = r_dig;
        n_let   = r_let;
        unique case (r_mode)
            M_IDENT: begin
                if (stt_pkg::is_word(i_char)) begin
                    if (stt_pkg::is_digit(i_char)) begin
                        n_dig = 1'b1;
                    end else begin
                        n_let = 1'b1;
                    end
                    pre[0]  = stt_pkg::mk_char(i_char);
                    pre_cnt = 3'd1;
                end else begin
                    pre[0]  = stt_pkg::mk_end((r_dig && !r_let) ?
                                              stt_pkg::CLS_NUMBER : stt_pkg::CLS_IDENT);
                    pre_cnt = 3'd1;
                    do_idle = 1'b1;
                end
            end
            M_SPACES: begin
                if (i_char == stt_pkg::CH_SPACE) begin
                    pre[0]  = stt_pkg::mk_char(i_char);
                    pre_cnt = 3'd1;
                end else begin
                    pre[0]  = stt_pkg::mk_end(stt_pkg::CLS_SPACES);
                    pre_cnt = 3'd1;
                    do_idle = 1'b1;
                end
            end
            M_SLASH: begin
                if (i_char == stt_pkg::CH_STAR) begin
                    n_mode = i_cfg.comments_enable ? M_BLOCK_KEEP : M_BLOCK_DROP;
                end else if (i_char == stt_pkg::CH_SLASH) begin
                    n_mode = i_cfg.comments_enable ? M_LINE_KEEP : M_LINE_DROP;
                end else begin
                    // lone slash: an operator token, then lex this byte afresh
                    pre[0]  = stt_pkg::mk_char(stt_pkg::CH_SLASH);
                    pre[1]  = stt_pkg::mk_end(stt_pkg::CLS_OPERATOR);
                    pre_cnt = 3'd2;
                    do_idle = 1'b1;
                end
            end
            M_BLOCK_KEEP, M_BSTAR_KEEP, M_BLOCK_DROP, M_BSTAR_DROP: begin
                if (i_char == stt_pkg::CH_NUL) begin
                    pre[0]  = stt_pkg::mk_err(stt_pkg::ERR_OPEN_COMMENT);
                    pre_cnt = 3'd1;
                    n_mode  = M_IDLE;
                end else if (star && (i_char == stt_pkg::CH_SLASH)) begin
                    pre[0]  = stt_pkg::mk_end(stt_pkg::CLS_COMMENT);
                    pre_cnt = keep ? 3'd1 : 3'd0;
                    n_mode  = M_IDLE;
                end else if (i_char == stt_pkg::CH_STAR) begin
                    // a held star is flushed only when the next byte is not a slash
                    pre[0]  = stt_pkg::mk_char(stt_pkg::CH_STAR);
                    pre_cnt = (star && keep) ? 3'd1 : 3'd0;
                    n_mode  = keep ? M_BSTAR_KEEP : M_BSTAR_DROP;
                end else begin
                    if (star && keep) begin
                        pre[0]  = stt_pkg::mk_char(stt_pkg::CH_STAR);
                        pre[1]  = stt_pkg::mk_char(i_char);
                        pre_cnt = 3'd2;
                    end else begin
                        pre[0]  = stt_pkg::mk_char(i_char);
                        pre_cnt = keep ? 3'd1 : 3'd0;
                    end
                    n_mode = keep ? M_BLOCK_KEEP : M_BLOCK_DROP;
                end
            end
            M_LINE_KEEP, M_LINE_DROP: begin
                if ((i_char == stt_pkg::CH_NUL) || (i_char == stt_pkg::CH_NL)) begin
                    pre[0]  = stt_pkg::mk_end(stt_pkg::CLS_COMMENT);
                    pre_cnt = (r_mode == M_LINE_KEEP) ? 3'd1 : 3'd0;
                    do_idle = 1'b1;
                end else begin
                    pre[0]  = stt_pkg::mk_char(i_char);
                    pre_cnt = (r_mode == M_LINE_KEEP) ? 3'd1 : 3'd0;
                end
            end
            M_ESCAPE: begin
                case (i_char) inside
                    stt_pkg::CH_LO_N, stt_pkg::CH_LO_T, stt_pkg::CH_LO_R,
                    stt_pkg::CH_LO_V, stt_pkg::CH_ZERO, stt_pkg::CH_BSLASH,
                    stt_pkg::CH_DQUOTE, stt_pkg::CH_QUOTE, stt_pkg::CH_BS: begin
                        pre[0]  = stt_pkg::mk_char(stt_pkg::CH_BSLASH);
                        pre[1]  = stt_pkg::mk_char((i_char == stt_pkg::CH_BS) ?
                                                   stt_pkg::CH_LO_B : i_char);
                        pre[2]  = stt_pkg::mk_end(stt_pkg::CLS_ESCAPE);
                        pre_cnt = 3'd3;
                        n_mode  = M_IDLE;
                    end
                    default: begin
                        pre[0]  = stt_pkg::mk_err(stt_pkg::ERR_BAD_ESCAPE);
                        pre_cnt = 3'd1;
                        n_mode  = M_IDLE;
                    end
                endcase
            end
            M_STRING: begin
                if (i_char == stt_pkg::CH_NUL) begin
                    pre[0]  = stt_pkg::mk_err(stt_pkg::ERR_OPEN_STRING);
                    pre_cnt = 3'd1;
                    n_mode  = M_IDLE;
                end else if (i_char == stt_pkg::CH_DQUOTE) begin
                    pre[0]  = stt_pkg::mk_end(stt_pkg::CLS_STRING);
                    pre_cnt = 3'd1;
                    n_mode  = M_IDLE;
                end else if (i_char == stt_pkg::CH_BSLASH) begin
                    n_mode = M_STR_ESC;
                end else if (raw != stt_pkg::CH_NUL) begin
                    pre[0]  = stt_pkg::mk_char(stt_pkg::CH_BSLASH);
                    pre[1]  = stt_pkg::mk_char(raw);
                    pre_cnt = 3'd2;
                end else begin
                    pre[0]  = stt_pkg::mk_char(i_char);
                    pre_cnt = 3'd1;
                end
            end
            M_STR_ESC, M_CHAR_ESC: begin
                if (stt_pkg::lit_escape(i_char)) begin
                    pre[0]  = stt_pkg::mk_char(stt_pkg::CH_BSLASH);
                    pre[1]  = stt_pkg::mk_char(i_char);
                    pre_cnt = 3'd2;
                    n_mode  = (r_mode == M_STR_ESC) ? M_STRING : M_CHAR_CLOSE;
                end else begin
                    pre[0]  = stt_pkg::mk_err(stt_pkg::ERR_BAD_ESCAPE);
                    pre_cnt = 3'd1;
                    n_mode  = M_IDLE;
                end
            end
            M_CHAR_FIRST: begin
                if ((i_char == stt_pkg::CH_NUL) || (i_char == stt_pkg::CH_QUOTE)) begin
                    pre[0]  = stt_pkg::mk_err(stt_pkg::ERR_EMPTY_CHAR);
                    pre_cnt = 3'd1;
                    n_mode  = M_IDLE;
                end else if (i_char == stt_pkg::CH_BSLASH) begin
                    n_mode = M_CHAR_ESC;
                end else begin
                    if (raw != stt_pkg::CH_NUL) begin
                        pre[0]  = stt_pkg::mk_char(stt_pkg::CH_BSLASH);
                        pre[1]  = stt_pkg::mk_char(raw);
                        pre_cnt = 3'd2;
                    end else begin
                        pre[0]  = stt_pkg::mk_char(i_char);
                        pre_cnt = 3'd1;
                    end
                    n_mode = M_CHAR_CLOSE;
                end
            end
            M_CHAR_CLOSE: begin
                if (i_char == stt_pkg::CH_QUOTE) begin
                    pre[0] = stt_pkg::mk_end(stt_pkg::CLS_CHAR);
                end else begin
                    pre[0] = stt_pkg::mk_err(stt_pkg::ERR_UNCLOSED_CHAR);
                end
                pre_cnt = 3'd1;
                n_mode  = M_IDLE;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase
        if (do_idle) begin
            n_mode = id_mode;
            n_dig  = id_dig;
            n_let  = id_let;
        end
    end

    // merge: mode results first, then start-of-token results
    always_comb begin
        o_lex.cnt = pre_cnt + (do_idle ? {1'b0, id_cnt} : 3'd0);
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < pre_cnt) begin
                o_lex.res[k] = pre[k];
            end else if ((3'(k) - pre_cnt) == 3'd0) begin
                o_lex.res[k] = id_res[0];
            end else begin
                o_lex.res[k] = id_res[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_dig  <= 1'b0;
            r_let  <= 1'b0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_dig  <= n_dig;
            r_let  <= n_let;
        end
    end

endmodule

>>> rtl/stt_outbuf.sv
// ----------------------------------------------------------------------------
// stt_outbuf: result register bank
// Holds up to four results of one byte, drains them one per ready cycle.
// ----------------------------------------------------------------------------
module stt_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  stt_pkg::t_lex_out  i_lex,
    input  logic               i_m_ready,
    output logic               o_in_ready,
    output logic               o_valid,
    output stt_pkg::t_res      o_res,
    output logic               o_last
);

    stt_pkg::t_res r_ent [4];
    stt_pkg::t_res n_ent [4];
    logic [3:0]    r_last, n_last;
    logic [2:0]    r_cnt, n_cnt;
    logic          pop;

    assign o_valid    = (r_cnt != 3'd0);
    assign o_res      = r_ent[0];
    assign o_last     = r_last[0];
    assign pop        = o_valid && i_m_ready;
    // take a new byte once the bank is empty or its final item leaves now
    assign o_in_ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_m_ready);

    always_comb begin
        n_cnt = r_cnt;
        for (int i = 0; i < 4; i++) begin
            n_ent[i] = r_ent[i];
        end
        n_last = r_last;
        if (i_load) begin
            n_cnt = i_lex.cnt;
            for (int i = 0; i < 4; i++) begin
                n_ent[i]  = i_lex.res[i];
                n_last[i] = (3'(i) == (i_lex.cnt - 3'd1));
            end
        end else if (pop) begin
            n_cnt = r_cnt - 3'd1;
            for (int i = 0; i < 3; i++) begin
                n_ent[i]  = r_ent[i+1];
                n_last[i] = r_last[i+1];
            end
            n_last[3] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_ent[i] <= n_ent[i];
        end
        r_last <= n_last;
    end

endmodule

>>> rtl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming source lexer, one byte per item
// Emits token characters, token ends carrying a class, or an error item.
// ----------------------------------------------------------------------------
// Latency: the first result of a byte is presented the cycle after it is taken.
// Throughput: one byte per cycle while each byte yields at most one result and
//   the output is ready; a byte with more results (up to 4) holds the input
//   until its last one leaves the single output port, one item per ready cycle.
// Reset (synchronous, active low): lexer back to idle, run flags cleared, all
//   four enables set, result bank emptied.
module source_text_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] char_in
    // result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // [7:0] char_value, [12:8] token_class,
                                      // [15:13] error_code
    output logic [1:0]  o_m_tuser,    // [1:0] item_type
    output logic        o_m_tlast,    // final result of the byte
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data
);

    stt_pkg::t_cfg     r_cfg;
    stt_pkg::t_lex_out lex;
    stt_pkg::t_res     res;
    logic              load;
    logic              buf_ready;

    // Configuration: always ready; user must write only while block is quiet.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stt_pkg::REG_SPACES:   r_cfg.spaces_enable   <= i_cfg_data;
                stt_pkg::REG_TABS:     r_cfg.tabs_enable     <= i_cfg_data;
                stt_pkg::REG_NEWLINES: r_cfg.newlines_enable <= i_cfg_data;
                stt_pkg::REG_COMMENTS: r_cfg.comments_enable <= i_cfg_data;
                default:               r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Take a byte whenever the result bank can be reloaded this cycle; the
    // lexer advances its mode on the same edge that the bank loads.
    assign o_s_tready = buf_ready;
    assign load       = i_s_tvalid && buf_ready;

    stt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (load),
        .i_char  (i_s_tdata),
        .i_cfg   (r_cfg),
        .o_lex   (lex)
    );

    // Hold the results of the byte and drain them in order, last one marked.
    stt_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_lex      (lex),
        .i_m_ready  (i_m_tready),
        .o_in_ready (buf_ready),
        .o_valid    (o_m_tvalid),
        .o_res      (res),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {res.error_code, res.token_class, res.char_value};
    assign o_m_tuser = res.item_type;

endmodule

>>> tb/sv/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb: self-checking bench for the streaming tokenizer
// Feeds source bytes through the input stream, runs an in-bench lexer on every
// accepted byte and matches each result item field by field, in order, under
// random stalls on both streams and across several enable settings.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;

    localparam int SIDE_SRC     = 0;
    localparam int SIDE_SNK     = 1;
    localparam int TAIL_CYCLES  = 8;     // settle time after the last result
    localparam int PHASE_BYTES  = 95;

    // lexer modes of the in-bench predictor
    typedef enum logic [3:0] {
        SC_IDLE, SC_WORD, SC_SPACES, SC_SLASH,
        SC_BLK_KEEP, SC_BSTAR_KEEP, SC_BLK_DROP, SC_BSTAR_DROP,
        SC_LINE_KEEP, SC_LINE_DROP, SC_ESCAPE, SC_STRING,
        SC_STR_ESC, SC_CHAR_FIRST, SC_CHAR_ESC, SC_CHAR_CLOSE
    } t_scan_mode;

    typedef struct packed {
        stt_pkg::t_res res;
        logic          last;
    } t_tok_result;

    // DUT connections
    logic        i_clk       = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic        i_cfg_data;

    // predictor state
    t_scan_mode    scan_mode;
    bit            saw_digit;
    bit            saw_alpha;
    stt_pkg::t_cfg cfg_model;
    stt_pkg::t_res step_out[$];

    // stimulus and expectations
    logic [7:0]  source_bytes[$];
    t_tok_result expected_results[$];
    int unsigned bytes_queued;

    // stream pacing
    bit          src_fire;
    bit          snk_fire;
    int unsigned src_gap;
    int unsigned snk_stall;
    int unsigned stretch_left[2];
    bit          stretch_calm[2];

    // run statistics
    int unsigned fail_count;
    int unsigned bytes_lexed;
    int unsigned results_seen;
    int unsigned token_ends;
    int unsigned error_items;
    int unsigned reg_writes;

    source_text_tokenizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),     // [7:0] char_in
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),     // [7:0] char_value, [12:8] token_class,
                                      // [15:13] error_code
        .o_m_tuser   (o_m_tuser),     // [1:0] item_type
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor: byte classes and literal rewrites
    // ------------------------------------------------------------------------
    function automatic bit is_num(logic [7:0] c);
        return c inside {[stt_pkg::CH_ZERO:stt_pkg::CH_NINE]};
    endfunction

    function automatic bit is_word_byte(logic [7:0] c);
        return is_num(c) || c == stt_pkg::CH_UNDER ||
               c inside {[stt_pkg::CH_LO_A:stt_pkg::CH_LO_Z]} ||
               c inside {[stt_pkg::CH_UP_A:stt_pkg::CH_UP_Z]};
    endfunction

    // letters allowed after a backslash inside string and char literals
    function automatic bit lit_letter_ok(logic [7:0] c);
        return c inside {stt_pkg::CH_LO_N, stt_pkg::CH_LO_T, stt_pkg::CH_LO_V,
                         stt_pkg::CH_LO_R, stt_pkg::CH_LO_F, stt_pkg::CH_LO_B,
                         stt_pkg::CH_LO_A, stt_pkg::CH_BSLASH, stt_pkg::CH_QMARK,
                         stt_pkg::CH_DQUOTE, stt_pkg::CH_QUOTE, stt_pkg::CH_ZERO};
    endfunction

    // second character of the escaped spelling of a raw literal byte, NUL if kept
    function automatic logic [7:0] raw_letter(logic [7:0] c);
        case (c)
            stt_pkg::CH_NL:  return stt_pkg::CH_LO_N;
            stt_pkg::CH_TAB: return stt_pkg::CH_LO_T;
            stt_pkg::CH_VT:  return stt_pkg::CH_LO_V;
            stt_pkg::CH_CR:  return stt_pkg::CH_LO_R;
            stt_pkg::CH_FF:  return stt_pkg::CH_LO_F;
            stt_pkg::CH_BS:  return stt_pkg::CH_LO_B;
            stt_pkg::CH_BEL: return stt_pkg::CH_LO_A;
            stt_pkg::CH_BSLASH, stt_pkg::CH_QMARK,
            stt_pkg::CH_DQUOTE, stt_pkg::CH_QUOTE: return c;
            default: return stt_pkg::CH_NUL;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: result builders
    // ------------------------------------------------------------------------
    function automatic void emit(logic [1:0] kind, logic [7:0] ch, logic [4:0] cls,
                                 logic [2:0] ecode);
        stt_pkg::t_res r;
        r.item_type   = kind;
        r.char_value  = ch;
        r.token_class = cls;
        r.error_code  = ecode;
        step_out.push_back(r);
    endfunction

    function automatic void emit_char(logic [7:0] c);
        emit(stt_pkg::ITEM_CHAR, c, '0, '0);
    endfunction

    function automatic void emit_end(logic [4:0] cls);
        emit(stt_pkg::ITEM_END, '0, cls, '0);
    endfunction

    // an error abandons the current token and drops the lexer back to idle
    function automatic void emit_err(logic [2:0] ecode);
        emit(stt_pkg::ITEM_ERR, '0, '0, ecode);
        scan_mode = SC_IDLE;
    endfunction

    function automatic void emit_pair(logic [7:0] c);
        emit_char(stt_pkg::CH_BSLASH);
        emit_char(c);
    endfunction

    function automatic void emit_single(logic [7:0] c, logic [4:0] cls);
        emit_char(c);
        emit_end(cls);
    endfunction

    // raw byte inside a literal: rewrite control and quote bytes, pass the rest
    function automatic void emit_lit_byte(logic [7:0] c);
        logic [7:0] l;
        l = raw_letter(c);
        if (l != stt_pkg::CH_NUL) emit_pair(l);
        else emit_char(c);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: lexer
    // ------------------------------------------------------------------------
    // Lex a byte as the first byte of a new token.
    function automatic void start_token(logic [7:0] c);
        scan_mode = SC_IDLE;
        if (c == stt_pkg::CH_NUL) begin
            emit_end(stt_pkg::CLS_EOF);
        end else if (is_word_byte(c)) begin
            saw_digit = is_num(c);
            saw_alpha = !is_num(c);
            scan_mode = SC_WORD;
            emit_char(c);
        end else begin
            case (c)
                stt_pkg::CH_SLASH: scan_mode = SC_SLASH;
                stt_pkg::CH_CARET, stt_pkg::CH_STAR, stt_pkg::CH_PLUS,
                stt_pkg::CH_MINUS, stt_pkg::CH_EQ:
                    emit_single(c, stt_pkg::CLS_OPERATOR);
                stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN:
                    emit_single(c, stt_pkg::CLS_PAREN);
                stt_pkg::CH_LBRACE, stt_pkg::CH_RBRACE:
                    emit_single(c, stt_pkg::CLS_BRACE);
                stt_pkg::CH_LBRACK, stt_pkg::CH_RBRACK:
                    emit_single(c, stt_pkg::CLS_BRACKET);
                stt_pkg::CH_BSLASH: scan_mode = SC_ESCAPE;
                stt_pkg::CH_TAB:
                    if (cfg_model.tabs_enable) emit_single(c, stt_pkg::CLS_TAB);
                stt_pkg::CH_NL:
                    if (cfg_model.newlines_enable) emit_single(c, stt_pkg::CLS_NEWLINE);
                stt_pkg::CH_DQUOTE: scan_mode = SC_STRING;
                stt_pkg::CH_QUOTE:  scan_mode = SC_CHAR_FIRST;
                stt_pkg::CH_SPACE: begin
                    // the enable is sampled once, on the first space of a run
                    if (cfg_model.spaces_enable) begin
                        scan_mode = SC_SPACES;
                        emit_char(c);
                    end
                end
                stt_pkg::CH_DOT:     emit_single(c, stt_pkg::CLS_DOT);
                stt_pkg::CH_COLON:   emit_single(c, stt_pkg::CLS_COLON);
                stt_pkg::CH_SEMI:    emit_single(c, stt_pkg::CLS_SEMICOLON);
                stt_pkg::CH_GT:      emit_single(c, stt_pkg::CLS_GREATER);
                stt_pkg::CH_LT:      emit_single(c, stt_pkg::CLS_LESS);
                stt_pkg::CH_BAR:     emit_single(c, stt_pkg::CLS_BAR);
                stt_pkg::CH_PERCENT: emit_single(c, stt_pkg::CLS_PERCENT);
                default:             emit_single(c, stt_pkg::CLS_OTHER);
            endcase
        end
    endfunction

    // Block comment body; a pending star is emitted only when no slash follows.
    function automatic void scan_block(logic [7:0] c, bit keep, bit star);
        if (c == stt_pkg::CH_NUL) begin
            emit_err(stt_pkg::ERR_OPEN_COMMENT);
        end else if (star && c == stt_pkg::CH_SLASH) begin
            if (keep) emit_end(stt_pkg::CLS_COMMENT);
            scan_mode = SC_IDLE;
        end else begin
            if (star && keep) emit_char(stt_pkg::CH_STAR);
            if (c == stt_pkg::CH_STAR) begin
                scan_mode = keep ? SC_BSTAR_KEEP : SC_BSTAR_DROP;
            end else begin
                if (keep) emit_char(c);
                scan_mode = keep ? SC_BLK_KEEP : SC_BLK_DROP;
            end
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        case (scan_mode)
            SC_WORD: begin
                if (is_word_byte(c)) begin
                    if (is_num(c)) saw_digit = 1'b1;
                    else saw_alpha = 1'b1;
                    emit_char(c);
                end else begin
                    emit_end((saw_digit && !saw_alpha) ?
                             stt_pkg::CLS_NUMBER : stt_pkg::CLS_IDENT);
                    start_token(c);
                end
            end
            SC_SPACES: begin
                if (c == stt_pkg::CH_SPACE) begin
                    emit_char(c);
                end else begin
                    emit_end(stt_pkg::CLS_SPACES);
                    start_token(c);
                end
            end
            SC_SLASH: begin
                // comments_enable is sampled here, on the second opener byte
                if (c == stt_pkg::CH_STAR) begin
                    scan_mode = cfg_model.comments_enable ? SC_BLK_KEEP : SC_BLK_DROP;
                end else if (c == stt_pkg::CH_SLASH) begin
                    scan_mode = cfg_model.comments_enable ? SC_LINE_KEEP : SC_LINE_DROP;
                end else begin
                    emit_single(stt_pkg::CH_SLASH, stt_pkg::CLS_OPERATOR);
                    start_token(c);
                end
            end
            SC_BLK_KEEP:   scan_block(c, 1'b1, 1'b0);
            SC_BSTAR_KEEP: scan_block(c, 1'b1, 1'b1);
            SC_BLK_DROP:   scan_block(c, 1'b0, 1'b0);
            SC_BSTAR_DROP: scan_block(c, 1'b0, 1'b1);
            SC_LINE_KEEP, SC_LINE_DROP: begin
                // newline or end of input closes the comment and is lexed on its own
                if (c == stt_pkg::CH_NUL || c == stt_pkg::CH_NL) begin
                    if (scan_mode == SC_LINE_KEEP) emit_end(stt_pkg::CLS_COMMENT);
                    start_token(c);
                end else if (scan_mode == SC_LINE_KEEP) begin
                    emit_char(c);
                end
            end
            SC_ESCAPE: begin
                case (c)
                    stt_pkg::CH_LO_N, stt_pkg::CH_LO_T, stt_pkg::CH_LO_R,
                    stt_pkg::CH_LO_V, stt_pkg::CH_ZERO, stt_pkg::CH_BSLASH,
                    stt_pkg::CH_DQUOTE, stt_pkg::CH_QUOTE: begin
                        emit_pair(c);
                        emit_end(stt_pkg::CLS_ESCAPE);
                        scan_mode = SC_IDLE;
                    end
                    stt_pkg::CH_BS: begin
                        emit_pair(stt_pkg::CH_LO_B);
                        emit_end(stt_pkg::CLS_ESCAPE);
                        scan_mode = SC_IDLE;
                    end
                    default: emit_err(stt_pkg::ERR_BAD_ESCAPE);
                endcase
            end
            SC_STRING: begin
                if (c == stt_pkg::CH_NUL) begin
                    emit_err(stt_pkg::ERR_OPEN_STRING);
                end else if (c == stt_pkg::CH_DQUOTE) begin
                    emit_end(stt_pkg::CLS_STRING);
                    scan_mode = SC_IDLE;
                end else if (c == stt_pkg::CH_BSLASH) begin
                    scan_mode = SC_STR_ESC;
                end else begin
                    emit_lit_byte(c);
                end
            end
            SC_STR_ESC: begin
                if (lit_letter_ok(c)) begin
                    emit_pair(c);
                    scan_mode = SC_STRING;
                end else begin
                    emit_err(stt_pkg::ERR_BAD_ESCAPE);
                end
            end
            SC_CHAR_FIRST: begin
                if (c == stt_pkg::CH_NUL || c == stt_pkg::CH_QUOTE) begin
                    emit_err(stt_pkg::ERR_EMPTY_CHAR);
                end else if (c == stt_pkg::CH_BSLASH) begin
                    scan_mode = SC_CHAR_ESC;
                end else begin
                    emit_lit_byte(c);
                    scan_mode = SC_CHAR_CLOSE;
                end
            end
            SC_CHAR_ESC: begin
                if (lit_letter_ok(c)) begin
                    emit_pair(c);
                    scan_mode = SC_CHAR_CLOSE;
                end else begin
                    emit_err(stt_pkg::ERR_BAD_ESCAPE);
                end
            end
            SC_CHAR_CLOSE: begin
                if (c == stt_pkg::CH_QUOTE) begin
                    emit_end(stt_pkg::CLS_CHAR);
                    scan_mode = SC_IDLE;
                end else begin
                    emit_err(stt_pkg::ERR_UNCLOSED_CHAR);
                end
            end
            default: start_token(c);
        endcase
    endfunction

    // Lex one accepted byte and queue its results; the final one carries last.
    function automatic void predict_tokens(logic [7:0] c);
        t_tok_result t;
        step_out.delete();
        scan_byte(c);
        foreach (step_out[i]) begin
            t.res  = step_out[i];
            t.last = (i == step_out.size() - 1);
            expected_results.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        source_bytes.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_from(string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] word_char(bit digits_only);
        int unsigned r;
        r = $urandom_range(0, 62);
        if (digits_only || r < 10) return stt_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 36) return stt_pkg::CH_LO_A + 8'(r - 10);
        if (r < 62) return stt_pkg::CH_UP_A + 8'(r - 36);
        return stt_pkg::CH_UNDER;
    endfunction

    // One well-formed item of a string or char literal body.
    function automatic void add_lit_item(bit in_char);
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            b = 8'($urandom_range(32, 126));
            if (b == stt_pkg::CH_DQUOTE || b == stt_pkg::CH_BSLASH ||
                (in_char && b == stt_pkg::CH_QUOTE))
                b = stt_pkg::CH_LO_Z;
            add_byte(b);
        end else if (r == 4) begin
            add_byte(8'($urandom_range(128, 255)));
        end else if (r < 7) begin
            // raw bytes that come out in escaped form
            if ($urandom_range(0, 7) == 0)
                add_byte(in_char ? stt_pkg::CH_DQUOTE : stt_pkg::CH_QUOTE);
            else add_byte(pick_from("\007\010\t\n\013\014\r?"));
        end else begin
            add_byte(stt_pkg::CH_BSLASH);
            add_byte(pick_from("ntvrfba\\?\"'0"));
        end
    endfunction

    // A byte that no escape accepts.
    function automatic logic [7:0] bad_escape_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (lit_letter_ok(b) || b == stt_pkg::CH_BS) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Append one random token; mostly well formed, some broken, some noise.
    function automatic void queue_token();
        int unsigned kind;
        int unsigned n;
        bit          digits_only;
        kind = $urandom_range(0, 19);
        case (kind)
            0, 1, 2, 3: begin
                digits_only = ($urandom_range(0, 2) == 0);
                n = $urandom_range(1, 6);
                repeat (n) add_byte(word_char(digits_only));
            end
            4, 18: repeat ($urandom_range(1, 4)) add_byte(stt_pkg::CH_SPACE);
            5: add_byte($urandom_range(0, 1) ? stt_pkg::CH_TAB : stt_pkg::CH_NL);
            6, 7, 8, 19: begin
                case ($urandom_range(0, 3))
                    0:       add_byte(pick_from("!#$&,@`~"));
                    1:       add_byte($urandom_range(1, 3) == 1 ?
                                      stt_pkg::CH_CR : 8'($urandom_range(128, 255)));
                    default: add_byte(pick_from("^*+-=(){}[].:;><|%"));
                endcase
            end
            9: add_byte(stt_pkg::CH_SLASH);
            10: begin
                add_byte(stt_pkg::CH_SLASH);
                add_byte(stt_pkg::CH_STAR);
                repeat ($urandom_range(0, 8))
                    add_byte($urandom_range(0, 3) == 0 ?
                             stt_pkg::CH_STAR : 8'($urandom_range(1, 255)));
                if ($urandom_range(0, 9) == 0) begin
                    add_byte(stt_pkg::CH_NUL);
                end else begin
                    add_byte(stt_pkg::CH_STAR);
                    add_byte(stt_pkg::CH_SLASH);
                end
            end
            11: begin
                add_byte(stt_pkg::CH_SLASH);
                add_byte(stt_pkg::CH_SLASH);
                repeat ($urandom_range(0, 8)) begin
                    n = $urandom_range(1, 255);
                    add_byte(n == stt_pkg::CH_NL ? stt_pkg::CH_LO_Z : n[7:0]);
                end
                add_byte($urandom_range(0, 7) == 0 ? stt_pkg::CH_NUL : stt_pkg::CH_NL);
            end
            12: begin
                add_byte(stt_pkg::CH_BSLASH);
                case ($urandom_range(0, 5))
                    0:       add_byte(bad_escape_byte());
                    1:       add_byte(stt_pkg::CH_BS);
                    default: add_byte(pick_from("ntrv0\\\"'"));
                endcase
            end
            13, 14: begin
                add_byte(stt_pkg::CH_DQUOTE);
                repeat ($urandom_range(0, 6)) add_lit_item(1'b0);
                case ($urandom_range(0, 9))
                    0: begin
                        add_byte(stt_pkg::CH_BSLASH);
                        add_byte(bad_escape_byte());
                    end
                    1:       add_byte(stt_pkg::CH_NUL);
                    default: add_byte(stt_pkg::CH_DQUOTE);
                endcase
            end
            15: begin
                add_byte(stt_pkg::CH_QUOTE);
                case ($urandom_range(0, 7))
                    0: add_byte($urandom_range(0, 1) ? stt_pkg::CH_QUOTE : stt_pkg::CH_NUL);
                    1: begin
                        add_lit_item(1'b1);
                        add_byte(pick_from("ab\"x;"));
                    end
                    2: begin
                        add_byte(stt_pkg::CH_BSLASH);
                        add_byte(bad_escape_byte());
                    end
                    default: begin
                        add_lit_item(1'b1);
                        add_byte(stt_pkg::CH_QUOTE);
                    end
                endcase
            end
            16: add_byte(stt_pkg::CH_NUL);
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stream pacing: waits come in stretches, some with no idling at all
    // ------------------------------------------------------------------------
    function automatic int unsigned next_wait(int side);
        if (stretch_left[side] == 0) begin
            stretch_left[side] = $urandom_range(16, 64);
            stretch_calm[side] = ($urandom_range(0, 3) == 0);
        end
        stretch_left[side]--;
        if (stretch_calm[side]) return 0;
        return $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------------
    // Source driver: sample the handshake at the rising edge, predict there,
    // change the inputs at the falling edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : take_bytes
        src_fire = i_rst_n && i_s_tvalid && o_s_tready;
        if (src_fire) begin
            predict_tokens(i_s_tdata);
            bytes_lexed++;
        end
    end

    always @(negedge i_clk) begin : feed_bytes
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || src_fire) begin
            // the previous item is gone: wait out its gap, then present the next
            if (src_gap != 0) begin
                src_gap--;
                i_s_tvalid <= 1'b0;
            end else if (source_bytes.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= source_bytes.pop_front();
                src_gap    = next_wait(SIDE_SRC);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        // otherwise hold the item until it is taken
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare every accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
                     $time, results_seen, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_tok_result want;
        snk_fire = i_rst_n && o_m_tvalid && i_m_tready;
        if (snk_fire) begin
            results_seen++;
            if (o_m_tuser == stt_pkg::ITEM_END) token_ends++;
            if (o_m_tuser == stt_pkg::ITEM_ERR) error_items++;
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual type %0d data %h",
                         $time, o_m_tuser, o_m_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("item_type",   want.res.item_type,   o_m_tuser);
                check_field("char_value",  want.res.char_value,  o_m_tdata[7:0]);
                check_field("token_class", want.res.token_class, o_m_tdata[12:8]);
                check_field("error_code",  want.res.error_code,  o_m_tdata[15:13]);
                check_field("last",        want.last,            o_m_tlast);
            end
        end
    end

    // Back-pressure: after each result, stall for a random number of cycles.
    always @(negedge i_clk) begin : pace_results
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (snk_fire) snk_stall = next_wait(SIDE_SNK);
            if (!i_m_tready || snk_fire) begin
                if (snk_stall != 0) begin
                    snk_stall--;
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    // Block until every byte is taken and every result has arrived, then give
    // bytes that make no result time to clear the block.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (source_bytes.size() != 0 || i_s_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            stt_pkg::REG_SPACES:   cfg_model.spaces_enable   = val;
            stt_pkg::REG_TABS:     cfg_model.tabs_enable     = val;
            stt_pkg::REG_NEWLINES: cfg_model.newlines_enable = val;
            stt_pkg::REG_COMMENTS: cfg_model.comments_enable = val;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : run_test
        stt_pkg::t_cfg setting;
        int unsigned   mark;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = stt_pkg::REG_SPACES;
        i_cfg_data  = 1'b0;
        scan_mode   = SC_IDLE;
        saw_digit   = 1'b0;
        saw_alpha   = 1'b0;
        cfg_model   = '1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed bytes with reset enables: a mixed identifier and a number,
        // spaces, a lone slash followed by an operator (four results), an
        // escape of the backspace byte, a string with a raw bell and an escaped
        // question mark, a char literal, a kept block comment, the top byte
        // value, a tab, a newline, a line comment closed by newline, and end
        // of input.
        add_text("a_9 4 /+\\");
        add_byte(stt_pkg::CH_BS);
        add_text("\"");
        add_byte(stt_pkg::CH_BEL);
        add_text("\\?\"'x'/*a*/");
        add_byte(8'hFF);
        add_text("\t\n//c\n");
        add_byte(stt_pkg::CH_NUL);
        wait_drained();

        // Random phases under different enables: all off, all on, and mixes.
        // Each phase ends with end of input so the lexer is idle when the
        // registers change, and the source holds off until all results are in.
        for (int p = 1; p <= 5; p++) begin
            case (p)
                1:       setting = '0;
                4:       setting = '1;
                default: setting = stt_pkg::t_cfg'(4'($urandom_range(0, 15)));
            endcase
            write_reg(stt_pkg::REG_SPACES,   setting.spaces_enable);
            write_reg(stt_pkg::REG_TABS,     setting.tabs_enable);
            write_reg(stt_pkg::REG_NEWLINES, setting.newlines_enable);
            write_reg(stt_pkg::REG_COMMENTS, setting.comments_enable);
            @(posedge i_clk);
            mark = bytes_queued;
            while (bytes_queued - mark < PHASE_BYTES) queue_token();
            add_byte(stt_pkg::CH_NUL);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Summary: %0d bytes lexed over 6 enable settings, %0d register writes",
                 bytes_lexed, reg_writes);
        $display("Summary: %0d results checked, %0d token ends, %0d error items",
                 results_seen, token_ends, error_items);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("source_text_tokenizer test passed");
        end else begin
            $display("source_text_tokenizer test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #1000000;
        $display("source_text_tokenizer test failed");
        $finish;
    end

endmodule

>>> source_text_tokenizer.f
rtl/stt_pkg.sv
rtl/stt_lexer.sv
rtl/stt_outbuf.sv
rtl/source_text_tokenizer.sv
tb/sv/source_text_tokenizer_tb.sv
